/* rtl/core/ldcf_pkg.sv */
`timescale 1ns / 1ps

package ldcf_pkg;

    localparam int PIX_W     = 8;
    localparam int ROW_W     = 12;
    localparam int OCOL_W    = 11;
    localparam int FRW_W     = 12;
    localparam int FRH_W     = 13;
    localparam int SPT_W     = 9;
    localparam int TPT_W     = 8;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int LANES     = 4;
    localparam int TLANES    = 2;
    localparam int TPIX      = 4;

    localparam int MAX_WIDTH_DEF = 2048;

    localparam int FRAME_W_MIN = 3;
    localparam int FRAME_H_MIN = 5;
    localparam int FRAME_H_MAX = 4096;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPATIAL_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMPORAL_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd3;

    localparam logic [SPT_W-1:0] SPATIAL_THR_RST  = 9'd20;
    localparam logic [TPT_W-1:0] TEMPORAL_THR_RST = 8'd20;
    localparam logic [FRW_W-1:0] FRAME_WIDTH_RST  = 12'd720;
    localparam logic [FRH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    // result slots emitted for one request
    localparam logic [1:0] SUB_MAIN  = 2'd0;
    localparam logic [1:0] SUB_ABOVE = 2'd1;
    localparam logic [1:0] SUB_CUR   = 2'd2;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 32;

    typedef struct packed {
        logic [ROW_W-1:0]  row;       // row of the request
        logic [OCOL_W-1:0] col;       // column of the request
        logic              has_out;   // at least one result
        logic              filt;      // output pixel lies inside the filter window
        logic              last_row;  // three results
        logic              frame_end; // final pixel of the frame
    } t_ctl;

    function automatic logic [SPT_W-1:0] adiff9(input logic [SPT_W-1:0] a,
                                                 input logic [SPT_W-1:0] b);
        adiff9 = (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [PIX_W-1:0] adiff8(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
        adiff8 = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

/* rtl/core/luma_dot_crawl_filter.sv */
`timescale 1ns / 1ps
// Pipeline: an accepted request passes the s1, s2 and s3 registers before its first result
//   appears on the result stream, where it is taken when m_axis_tready is high.
// Throughput: one request per cycle while results are taken, one read-modify-write of its column
//   word per request; a last-row request yields three results and stalls the pipeline meanwhile.
// Reset: synchronous, active low; clears counters, pipeline valids and the configuration
//   registers to their defaults. Row memories are not cleared and need no clearing pass.
module luma_dot_crawl_filter #(
    parameter int MAX_WIDTH = ldcf_pkg::MAX_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_wr_en,
    input  logic [ldcf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ldcf_pkg::CFG_W-1:0]          i_cfg_data,
    // request stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: cur_pixel[7:0], prev2_pixel[15:8], prev_pixel[23:16],
    //        next_pixel[31:24], next2_pixel[39:32]
    input  logic [ldcf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: out_pixel[7:0], out_row[19:8], out_col[30:20], zero[31]
    output logic [ldcf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast,  // last_of_run
    // tuser: frame_done[0]
    output logic                                m_axis_tuser
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int DEPTH = 1 << CW;
    localparam int PW    = ldcf_pkg::PIX_W;
    localparam int RWW   = PW * ldcf_pkg::LANES;          // row memory word
    localparam int TEW   = PW * ldcf_pkg::TPIX;           // one temporal entry
    localparam int TWW   = TEW * ldcf_pkg::TLANES;        // temporal memory word

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ldcf_pkg::SPT_W-1:0] r_sp_thr;
    logic [ldcf_pkg::TPT_W-1:0] r_tp_thr;
    logic [ldcf_pkg::FRW_W-1:0] r_fr_w;
    logic [ldcf_pkg::FRH_W-1:0] r_fr_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp_thr <= ldcf_pkg::SPATIAL_THR_RST;
            r_tp_thr <= ldcf_pkg::TEMPORAL_THR_RST;
            r_fr_w   <= ldcf_pkg::FRAME_WIDTH_RST;
            r_fr_h   <= ldcf_pkg::FRAME_HEIGHT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                ldcf_pkg::CFG_SPATIAL_THR:  r_sp_thr <= i_cfg_data[ldcf_pkg::SPT_W-1:0];
                ldcf_pkg::CFG_TEMPORAL_THR: r_tp_thr <= i_cfg_data[ldcf_pkg::TPT_W-1:0];
                ldcf_pkg::CFG_FRAME_WIDTH:  r_fr_w   <= i_cfg_data[ldcf_pkg::FRW_W-1:0];
                ldcf_pkg::CFG_FRAME_HEIGHT: r_fr_h   <= i_cfg_data[ldcf_pkg::FRH_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the frame size to what the row memories and counters can hold.
    logic [CW:0]                w_c;
    logic [ldcf_pkg::FRH_W-1:0] h_c;

    always_comb begin
        if (32'(r_fr_w) < 32'(ldcf_pkg::FRAME_W_MIN))
            w_c = (CW+1)'(ldcf_pkg::FRAME_W_MIN);
        else if (32'(r_fr_w) > 32'(MAX_WIDTH))
            w_c = (CW+1)'(MAX_WIDTH);
        else
            w_c = (CW+1)'(r_fr_w);

        if (32'(r_fr_h) < 32'(ldcf_pkg::FRAME_H_MIN))
            h_c = ldcf_pkg::FRH_W'(ldcf_pkg::FRAME_H_MIN);
        else if (32'(r_fr_h) > 32'(ldcf_pkg::FRAME_H_MAX))
            h_c = ldcf_pkg::FRH_W'(ldcf_pkg::FRAME_H_MAX);
        else
            h_c = r_fr_h;
    end

    // ------------------------------------------------------------------
    // Handshake and pipeline advance
    //   s1: memory read data, s2: filter decision, s3: output register
    // ------------------------------------------------------------------
    logic r_s1_v, r_s2_v, r_s3_v;
    logic accept, s2_adv, s3_free, s3_load, out_hs, last_sub;

    ldcf_pkg::t_ctl r_s1_ctl, r_s2_ctl, r_s3_ctl, n_ctl;
    logic [1:0]     r_sub;

    assign out_hs        = r_s3_v & m_axis_tready;
    assign last_sub      = !r_s3_ctl.last_row || (r_sub == ldcf_pkg::SUB_CUR);
    assign s3_free       = !r_s3_v || (out_hs && last_sub);
    assign s3_load       = r_s2_v && r_s2_ctl.has_out && s3_free;
    // a request with no result drops out of s2 on its own
    assign s2_adv        = !r_s2_v || !r_s2_ctl.has_out || s3_free;
    assign s_axis_tready = !r_s1_v || s2_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Raster position and classification of the incoming request
    // ------------------------------------------------------------------
    logic [CW-1:0]              r_col;
    logic [ldcf_pkg::ROW_W-1:0] r_row;
    logic [CW:0]                x_p1;
    logic [ldcf_pkg::FRH_W-1:0] y_p1;
    logic                       end_row, last_row;

    assign x_p1     = (CW+1)'(r_col) + (CW+1)'(1);
    assign y_p1     = ldcf_pkg::FRH_W'(r_row) + ldcf_pkg::FRH_W'(1);
    assign end_row  = x_p1 >= w_c;
    assign last_row = y_p1 >= h_c;

    always_comb begin
        n_ctl           = '0;
        n_ctl.row       = r_row;
        n_ctl.col       = ldcf_pkg::OCOL_W'(r_col);
        n_ctl.has_out   = r_row >= ldcf_pkg::ROW_W'(2);
        // output row y-2 must lie in 2..H-3 and the column in 1..W-2
        n_ctl.filt      = (r_row >= ldcf_pkg::ROW_W'(4)) && (y_p1 <= h_c)
                          && (r_col != '0) && !end_row;
        n_ctl.last_row  = last_row;
        n_ctl.frame_end = last_row && end_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (end_row) begin
                r_col <= '0;
                r_row <= last_row ? '0 : (r_row + ldcf_pkg::ROW_W'(1));
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Memories. Each column word of the row memory holds four rows, lane
    // y mod 4 holding row y. The temporal memory holds two rows of four
    // temporal neighbours, lane y mod 2. Read-first: the read at the
    // column being overwritten returns the row four (or two) rows back.
    // ------------------------------------------------------------------
    logic [RWW-1:0] r_row_mem [0:DEPTH-1];
    logic [TWW-1:0] r_tmp_mem [0:DEPTH-1];

    logic [RWW-1:0] r_rd_c, r_rd_r, r_rd_l;
    logic [TWW-1:0] r_rd_t;
    logic [PW-1:0]  r_s1_cur;
    logic [CW-1:0]  rd_addr_r;
    logic [PW-1:0]  in_cur, in_pp, in_p, in_n, in_nn;

    assign in_cur    = s_axis_tdata[PW-1:0];
    assign in_pp     = s_axis_tdata[2*PW-1:PW];
    assign in_p      = s_axis_tdata[3*PW-1:2*PW];
    assign in_n      = s_axis_tdata[4*PW-1:3*PW];
    assign in_nn     = s_axis_tdata[5*PW-1:4*PW];
    assign rd_addr_r = r_col + CW'(1);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            // the previous request's center word is this one's left neighbour
            r_rd_l <= r_rd_c;
            r_rd_c <= r_row_mem[r_col];
            r_rd_r <= r_row_mem[rd_addr_r];
            r_rd_t <= r_tmp_mem[r_col];
            r_row_mem[r_col][{r_row[1:0], 3'b000} +: PW] <= in_cur;
            r_tmp_mem[r_col][{r_row[0], 5'b00000} +: TEW] <= {in_nn, in_n, in_p, in_pp};
            r_s1_cur <= in_cur;
            r_s1_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= accept || (r_s1_v && !s2_adv);
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: pick lanes and decide whether to filter
    // ------------------------------------------------------------------
    logic [1:0]     lane_c, lane_a, lane_u;
    logic [TEW-1:0] tword;
    logic [PW-1:0]  pc, pl, pr, pa, pu, tpp, tp, tn, tnn;
    logic [ldcf_pkg::SPT_W-1:0] sd_h, sd_v;
    logic           spatial, stable, pick_n;

    assign lane_c = r_s1_ctl.row[1:0] + 2'd2;
    assign lane_a = r_s1_ctl.row[1:0];
    assign lane_u = r_s1_ctl.row[1:0] - 2'd1;

    assign pc    = r_rd_c[{lane_c, 3'b000} +: PW];
    assign pl    = r_rd_l[{lane_c, 3'b000} +: PW];
    assign pr    = r_rd_r[{lane_c, 3'b000} +: PW];
    assign pa    = r_rd_c[{lane_a, 3'b000} +: PW];
    assign pu    = r_rd_c[{lane_u, 3'b000} +: PW];
    assign tword = r_rd_t[{r_s1_ctl.row[0], 5'b00000} +: TEW];
    assign tpp   = tword[PW-1:0];
    assign tp    = tword[2*PW-1:PW];
    assign tn    = tword[3*PW-1:2*PW];
    assign tnn   = tword[4*PW-1:3*PW];

    assign sd_h = ldcf_pkg::adiff9({1'b0, pl} + {1'b0, pr}, {pc, 1'b0});
    assign sd_v = ldcf_pkg::adiff9({1'b0, pa} + {1'b0, r_s1_cur}, {pc, 1'b0});

    assign spatial = (sd_h > r_sp_thr) || (sd_v > r_sp_thr);
    assign stable  = (ldcf_pkg::adiff8(tp, tn) <= r_tp_thr)
                     && (ldcf_pkg::adiff8(pc, tpp) <= r_tp_thr)
                     && (ldcf_pkg::adiff8(pc, tnn) <= r_tp_thr);
    // N wins a tie
    assign pick_n  = ldcf_pkg::adiff8(tn, pc) <= ldcf_pkg::adiff8(tp, pc);

    logic [PW-1:0] r_s2_c, r_s2_x, r_s2_up, r_s2_cur;
    logic          r_s2_filt;

    always_ff @(posedge i_clk) begin
        if (s2_adv && r_s1_v) begin
            r_s2_ctl  <= r_s1_ctl;
            r_s2_c    <= pc;
            r_s2_x    <= pick_n ? tn : tp;
            r_s2_up   <= pu;
            r_s2_cur  <= r_s1_cur;
            r_s2_filt <= r_s1_ctl.filt && spatial && stable;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (s2_adv) begin
            r_s2_v <= r_s1_v;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: rounded average, load the output register
    // ------------------------------------------------------------------
    logic [PW:0]   avg_sum;
    logic [PW-1:0] pix_main;

    assign avg_sum  = {1'b0, r_s2_c} + {1'b0, r_s2_x} + (PW+1)'(1);
    assign pix_main = r_s2_filt ? avg_sum[PW:1] : r_s2_c;

    logic [PW-1:0] r_s3_main, r_s3_up, r_s3_cur;

    always_ff @(posedge i_clk) begin
        if (s3_load) begin
            r_s3_ctl  <= r_s2_ctl;
            r_s3_main <= pix_main;
            r_s3_up   <= r_s2_up;
            r_s3_cur  <= r_s2_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
            r_sub  <= ldcf_pkg::SUB_MAIN;
        end else if (s3_free) begin
            r_s3_v <= s3_load;
            r_sub  <= ldcf_pkg::SUB_MAIN;
        end else if (out_hs) begin
            // advance to the next result of a last-row request
            r_sub  <= r_sub + 2'd1;
        end
    end

    // ------------------------------------------------------------------
    // Output: row y-2, then on the last row rows y-1 and y
    // ------------------------------------------------------------------
    logic [PW-1:0]              o_pix;
    logic [ldcf_pkg::ROW_W-1:0] o_row;

    always_comb begin
        unique case (r_sub)
            ldcf_pkg::SUB_ABOVE: begin
                o_pix = r_s3_up;
                o_row = r_s3_ctl.row - ldcf_pkg::ROW_W'(1);
            end
            ldcf_pkg::SUB_CUR: begin
                o_pix = r_s3_cur;
                o_row = r_s3_ctl.row;
            end
            default: begin
                o_pix = r_s3_main;
                o_row = r_s3_ctl.row - ldcf_pkg::ROW_W'(2);
            end
        endcase
    end

    assign m_axis_tvalid = r_s3_v;
    assign m_axis_tdata  = {1'b0, r_s3_ctl.col, o_row, o_pix};
    assign m_axis_tlast  = last_sub;
    assign m_axis_tuser  = r_s3_ctl.frame_end && last_sub;

endmodule
